/* sv/pidl_pkg.sv */
package pidl_pkg;

  localparam int DataW = 32;
  localparam int PosW  = 6;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_READ   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  // Broadcast to every cell of the row in the cycle a command is accepted.
  typedef struct packed {
    logic             ins;
    logic             del;
    logic [PosW-1:0]  pos;
    logic [DataW-1:0] value;
  } shift_t;

endpackage

/* sv/pidl_cell.sv */
module pidl_cell #(
  parameter int INDEX = 0
) (
  input  logic                          clk,
  input  pidl_pkg::shift_t              ctl_i,
  input  logic [pidl_pkg::DataW-1:0]    left_i,
  input  logic [pidl_pkg::DataW-1:0]    right_i,
  output logic [pidl_pkg::DataW-1:0]    entry_o
);

  logic [pidl_pkg::DataW-1:0] entry_r, entry_nxt;
  logic [31:0]                pos_ext;
  logic                       above, at;

  assign pos_ext = 32'(ctl_i.pos);
  assign above   = 32'(INDEX) > pos_ext;
  assign at      = 32'(INDEX) == pos_ext;

  always_comb begin
    entry_nxt = entry_r;
    if (ctl_i.ins) begin
      // open a slot: cells above the position take their lower neighbor
      if (above) begin
        entry_nxt = left_i;
      end else if (at) begin
        entry_nxt = ctl_i.value;
      end
    end else if (ctl_i.del && (above || at)) begin
      // close the gap: take the upper neighbor
      entry_nxt = right_i;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_o = entry_r;

endmodule

/* sv/positional_insert_delete_list_core.sv */
// The result beat of an accepted command is registered and held until taken.
// Throughput: one command per cycle while out_ready is high; insert and delete shift
// the whole cell row in the cycle the command is accepted, so none blocks the next.
// Reset: synchronous active-low rst_n empties the list and drops the output beat;
// entry contents are not cleared and are never read before being written.
module positional_insert_delete_list_core #(
  parameter int CAPACITY = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           in_command,
  input  logic [pidl_pkg::PosW-1:0]            in_position,
  input  logic signed [pidl_pkg::DataW-1:0]    in_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [1:0]                           out_status,
  output logic [5:0]                           out_count,
  output logic signed [pidl_pkg::DataW-1:0]    out_read_value
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > pidl_pkg::PosW) ? CW : pidl_pkg::PosW;

  logic                          accept;
  logic [CW-1:0]                 count_r, count_nxt;
  logic                          out_valid_r;
  pidl_pkg::status_t             status_r, status_nxt;
  logic [5:0]                    out_count_r;
  logic [pidl_pkg::DataW-1:0]    rd_r, rd_nxt;
  logic [CMPW-1:0]               pos_ext, count_ext;
  logic                          full;
  pidl_pkg::cmd_t                cmd;
  pidl_pkg::shift_t              ctl;
  logic [pidl_pkg::DataW-1:0]    cell_q [CAPACITY];

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign cmd       = pidl_pkg::cmd_t'(in_command);
  assign pos_ext   = CMPW'(in_position);
  assign count_ext = CMPW'(count_r);
  assign full      = (count_r == CW'(CAPACITY));

  always_comb begin
    status_nxt = pidl_pkg::ST_OK;
    count_nxt  = count_r;
    rd_nxt     = '0;
    ctl.ins    = 1'b0;
    ctl.del    = 1'b0;
    ctl.pos    = in_position;
    ctl.value  = in_value;
    case (cmd)
      pidl_pkg::CMD_CLEAR: begin
        count_nxt = '0;
      end
      pidl_pkg::CMD_INSERT: begin
        if (pos_ext > count_ext) begin
          status_nxt = pidl_pkg::ST_BADPOS;
        end else if (full) begin
          status_nxt = pidl_pkg::ST_FULL;
        end else begin
          ctl.ins   = accept;
          count_nxt = count_r + CW'(1);
        end
      end
      pidl_pkg::CMD_DELETE: begin
        if (pos_ext >= count_ext) begin
          status_nxt = pidl_pkg::ST_BADPOS;
        end else begin
          ctl.del   = accept;
          count_nxt = count_r - CW'(1);
        end
      end
      default: begin
        if (pos_ext >= count_ext) begin
          status_nxt = pidl_pkg::ST_BADPOS;
        end else begin
          for (int k = 0; k < CAPACITY; k++) begin
            if (pos_ext == CMPW'(k)) begin
              rd_nxt = rd_nxt | cell_q[k];
            end
          end
        end
      end
    endcase
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [pidl_pkg::DataW-1:0] left_d, right_d;
    if (g == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_q[g+1];
    end
    pidl_cell #(.INDEX(g)) u_cell (
      .clk     (clk),
      .ctl_i   (ctl),
      .left_i  (left_d),
      .right_i (right_d),
      .entry_o (cell_q[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload: load on accept, hold while the beat waits
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r    <= status_nxt;
      out_count_r <= 6'(count_nxt);
      rd_r        <= rd_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_count      = out_count_r;
  assign out_read_value = rd_r;

endmodule

/* sv/pidl_checker.sv */
module pidl_checker #(
  parameter int CAPACITY = 32
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic [1:0]                        in_command,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [1:0]                        out_status,
  input logic [5:0]                        out_count,
  input logic signed [pidl_pkg::DataW-1:0] out_read_value
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_count)
      && $stable(out_read_value))
    else $error("stalled result beat changed");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != pidl_pkg::ST_OK) |-> out_read_value == '0)
    else $error("error beat carries nonzero read value");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (CAPACITY >= 64) || (int'(out_count) <= CAPACITY))
    else $error("count above capacity");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_command == pidl_pkg::CMD_CLEAR)
      |=> out_valid && (out_count == 6'd0) && (out_status == pidl_pkg::ST_OK))
    else $error("clear did not empty the list");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat survived reset");

endmodule

bind positional_insert_delete_list_core pidl_checker #(.CAPACITY(CAPACITY)) u_pidl_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_command     (in_command),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_status     (out_status),
  .out_count      (out_count),
  .out_read_value (out_read_value)
);
